/* src/a2c_pkg.sv */
// a2c_pkg: shared types and constants of the cubic atan2 pipeline
// depends on nothing; used by every module of the block
`default_nettype none

package a2c_pkg;

   localparam int R_FRAC = 16;
   localparam int Q_WIDTH = R_FRAC + 1;

   localparam logic [13:0] COEF_C3 = 14'd12865;
   localparam logic [15:0] COEF_C1 = 16'd64337;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   localparam int QUEUE_DEPTH = 32;
   localparam int QUEUE_PTR_W = 5;

   typedef struct packed {
      logic y_neg;
      logic x_neg;
      logic r_neg;
   } flags_type;

   // round(pi * mult / 2^quarters_shift) at frac_bits fractional bits
   function automatic logic [63:0] pi_fixed(input logic [1:0] mult,
                                            input int unsigned quarters_shift,
                                            input int unsigned frac_bits);
      logic [65:0] prod;
      int unsigned sh;
      prod = {2'b00, PI_Q60} * {64'd0, mult};
      sh = 60 + quarters_shift - frac_bits;
      pi_fixed = 64'((prod + (66'd1 << (sh - 1))) >> sh);
   endfunction

endpackage

`default_nettype wire

/* src/a2c_front.sv */
// a2c_front: two register stages forming the ratio numerator magnitude, denominator
// and the rounded long-division dividend; depends on a2c_pkg
`default_nettype none

module a2c_front #(
   parameter int IN_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic signed [IN_WIDTH-1:0]        in_y,
   input  wire logic signed [IN_WIDTH-1:0]        in_x,
   output logic                                   out_valid,
   output logic [IN_WIDTH+a2c_pkg::R_FRAC-1:0]    out_dividend,
   output logic [IN_WIDTH:0]                      out_divisor,
   output a2c_pkg::flags_type                     out_flags
);

   localparam int EW = IN_WIDTH + 2;
   localparam int DW = IN_WIDTH + a2c_pkg::R_FRAC;

   logic signed [EW-1:0]  ys, xs, ay, num, den;
   logic [IN_WIDTH-1:0]   mag_in;
   a2c_pkg::flags_type    flags_in;

   logic                  valid1_ff;
   logic [IN_WIDTH-1:0]   mag_ff;
   logic [IN_WIDTH:0]     den_ff;
   a2c_pkg::flags_type    flags1_ff;

   logic                  valid2_ff;
   logic [DW-1:0]         dividend_ff;
   logic [IN_WIDTH:0]     divisor_ff;
   a2c_pkg::flags_type    flags2_ff;

   always_comb begin
      ys = EW'(in_y);
      xs = EW'(in_x);
      ay = (ys < 0 ? -ys : ys) + EW'(1);
      if (xs < 0) begin
         num = xs + ay;
         den = ay - xs;
      end else begin
         num = xs - ay;
         den = xs + ay;
      end
      mag_in = IN_WIDTH'(num < 0 ? -num : num);
      flags_in.y_neg = ys < 0;
      flags_in.x_neg = xs < 0;
      flags_in.r_neg = num < 0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      den_ff      <= den[IN_WIDTH:0];
      flags1_ff   <= flags_in;
      dividend_ff <= {mag_ff, {a2c_pkg::R_FRAC{1'b0}}} + DW'(den_ff >> 1);
      divisor_ff  <= den_ff;
      flags2_ff   <= flags1_ff;
   end

   assign out_valid    = valid2_ff;
   assign out_dividend = dividend_ff;
   assign out_divisor  = divisor_ff;
   assign out_flags    = flags2_ff;

endmodule

`default_nettype wire

/* src/a2c_div.sv */
// a2c_div: restoring divider, one quotient bit per register stage
// depends on a2c_pkg
`default_nettype none

module a2c_div #(
   parameter int IN_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [IN_WIDTH+a2c_pkg::R_FRAC-1:0]   in_dividend,
   input  wire logic [IN_WIDTH:0]                     in_divisor,
   input  wire a2c_pkg::flags_type                    in_flags,
   output logic                                       out_valid,
   output logic [a2c_pkg::Q_WIDTH-1:0]                out_quot,
   output a2c_pkg::flags_type                         out_flags
);

   localparam int QW = a2c_pkg::Q_WIDTH;
   localparam int DW = IN_WIDTH + a2c_pkg::R_FRAC;
   localparam int RW = IN_WIDTH + 1;

   logic               valid_ff [QW];
   logic [RW-1:0]      rem_ff   [QW];
   logic [QW-1:0]      lo_ff    [QW];
   logic [QW-1:0]      quo_ff   [QW];
   logic [RW-1:0]      den_ff   [QW];
   a2c_pkg::flags_type flags_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic               v_cur;
      logic [RW-1:0]      rem_cur;
      logic [QW-1:0]      lo_cur;
      logic [QW-1:0]      quo_cur;
      logic [RW-1:0]      den_cur;
      a2c_pkg::flags_type fl_cur;
      logic [RW:0]        trial;
      logic               ge;
      logic [RW-1:0]      rem_in;

      if (k == 0) begin : g_first
         assign v_cur   = in_valid;
         assign rem_cur = {2'b00, in_dividend[DW-1:QW]};
         assign lo_cur  = in_dividend[QW-1:0];
         assign quo_cur = '0;
         assign den_cur = in_divisor;
         assign fl_cur  = in_flags;
      end else begin : g_next
         assign v_cur   = valid_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign lo_cur  = lo_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign fl_cur  = flags_ff[k-1];
      end

      assign trial  = {rem_cur, lo_cur[QW-1]};
      assign ge     = trial >= {1'b0, den_cur};
      assign rem_in = ge ? RW'(trial - {1'b0, den_cur}) : RW'(trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]   <= rem_in;
         lo_ff[k]    <= {lo_cur[QW-2:0], 1'b0};
         quo_ff[k]   <= {quo_cur[QW-2:0], ge};
         den_ff[k]   <= den_cur;
         flags_ff[k] <= fl_cur;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quo_ff[QW-1];
   assign out_flags = flags_ff[QW-1];

endmodule

`default_nettype wire

/* src/a2c_poly.sv */
// a2c_poly: cubic polynomial, quadrant base, sign and clamp over seven register stages
// depends on a2c_pkg
`default_nettype none

module a2c_poly #(
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [a2c_pkg::Q_WIDTH-1:0]   in_quot,
   input  wire a2c_pkg::flags_type            in_flags,
   output logic                               out_valid,
   output logic [ANGLE_FRAC_BITS+2:0]         out_angle
);

   localparam int QW = a2c_pkg::Q_WIDTH;
   localparam int AW = ANGLE_FRAC_BITS + 4;
   localparam int SH = 2 * a2c_pkg::R_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [AW-1:0] PI_Q =
      AW'(a2c_pkg::pi_fixed(2'd1, 0, ANGLE_FRAC_BITS));
   localparam logic signed [AW-1:0] BASE_POS =
      AW'(a2c_pkg::pi_fixed(2'd1, 2, ANGLE_FRAC_BITS));
   localparam logic signed [AW-1:0] BASE_NEG =
      AW'(a2c_pkg::pi_fixed(2'd3, 2, ANGLE_FRAC_BITS));

   logic [6:0]         valid_ff;
   a2c_pkg::flags_type flags_ff [6];
   logic [QW-1:0]      quot_ff  [4];

   logic [33:0]        sq_full;
   logic [32:0]        sq_ff;
   logic [32:0]        sq_rnd;
   logic [16:0]        r2_ff;
   logic [30:0]        cp_ff;
   logic [30:0]        cp_rnd;
   logic [15:0]        tm_ff;
   logic [32:0]        p_ff;
   logic [32:0]        p_rnd;
   logic [AW-1:0]      mag;
   logic signed [AW-1:0] ang_in, ang_ff;
   logic signed [AW-1:0] fin, fin_in;
   logic [ANGLE_FRAC_BITS+2:0] out_ff;

   assign sq_full = {17'd0, in_quot} * {17'd0, in_quot};
   assign sq_rnd  = sq_ff + 33'(1 << (a2c_pkg::R_FRAC - 1));
   assign cp_rnd  = cp_ff + 31'(1 << (a2c_pkg::R_FRAC - 1));
   assign p_rnd   = p_ff + 33'(33'd1 << (SH - 1));
   assign mag     = AW'(p_rnd >> SH);

   always_comb begin
      ang_in = (flags_ff[4].x_neg ? BASE_NEG : BASE_POS)
             + (flags_ff[4].r_neg ? signed'(mag) : -signed'(mag));
      fin = flags_ff[5].y_neg ? -ang_ff : ang_ff;
      priority if (fin > PI_Q) begin
         fin_in = PI_Q;
      end else if (fin < -PI_Q) begin
         fin_in = -PI_Q;
      end else begin
         fin_in = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      flags_ff[0] <= in_flags;
      quot_ff[0]  <= in_quot;
      for (int i = 1; i < 6; i++) begin
         flags_ff[i] <= flags_ff[i-1];
      end
      for (int i = 1; i < 4; i++) begin
         quot_ff[i] <= quot_ff[i-1];
      end
      sq_ff  <= sq_full[32:0];
      r2_ff  <= sq_rnd[32:16];
      cp_ff  <= 31'(a2c_pkg::COEF_C3) * 31'(r2_ff);
      tm_ff  <= a2c_pkg::COEF_C1 - {1'b0, cp_rnd[30:16]};
      p_ff   <= 33'(tm_ff) * 33'(quot_ff[3]);
      ang_ff <= ang_in;
      out_ff <= fin_in[ANGLE_FRAC_BITS+2:0];
   end

   assign out_valid = valid_ff[6];
   assign out_angle = out_ff;

endmodule

`default_nettype wire

/* src/a2c_fifo.sv */
// a2c_fifo: result queue between the free-running pipeline and the response channel
// depends on a2c_pkg
`default_nettype none

module a2c_fifo #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_valid,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   output logic                       rd_valid,
   input  wire logic                  rd_ready,
   output logic [DATA_WIDTH-1:0]      rd_data
);

   localparam int PW = a2c_pkg::QUEUE_PTR_W;

   logic [DATA_WIDTH-1:0] mem [a2c_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic          load;

   // refill the output register when it is empty or being taken
   assign load         = (count_ff != '0) & (~out_valid_ff | rd_ready);
   assign wr_ptr_in    = wr_ptr_ff + PW'(wr_valid);
   assign rd_ptr_in    = rd_ptr_ff + PW'(load);
   assign count_in     = count_ff + (PW+1)'(wr_valid) - (PW+1)'(load);
   assign out_valid_in = load | (out_valid_ff & ~rd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem[wr_ptr_ff] <= wr_data;
      end
      if (load) begin
         out_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_valid = out_valid_ff;
   assign rd_data  = out_data_ff;

endmodule

`default_nettype wire

/* src/atan2_cubic_approx.sv */
// atan2_cubic_approx: four-quadrant arctangent by a cubic polynomial in the ratio
// depends on a2c_pkg, a2c_front, a2c_div, a2c_poly, a2c_fifo
//
// usage: each request on the req_ channel carries one signed (y, x) pair; each response
// on the rsp_ channel carries the angle as signed fixed point with ANGLE_FRAC_BITS
// fractional bits, clamped to plus or minus pi, one response per request, in order.
// the datapath is a free-running pipeline: two setup stages, one divider stage per
// quotient bit (17), seven polynomial and clamp stages, then a 32-entry result queue
// with a registered read port.
// a response passes through the register stages above into the queue, then through the
// queue's output register, before it can be taken; one request can be accepted every
// cycle while fewer than 32 requests are outstanding.
// req_tready depends only on a count of requests in flight or queued: while the
// receiver stalls, requests keep being accepted until 32 are outstanding, after which
// req_tready drops until a response is taken. nothing is lost or repeated.
// reset (synchronous, active high) empties the pipeline and the queue; no clearing
// pass is needed, req_tready is high in the first cycle after reset.
`default_nettype none

module atan2_cubic_approx #(
   parameter int IN_WIDTH = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // y_in, x_in
   input  wire logic [((2*IN_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // angle_out
   output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0]     rsp_tdata
);

   localparam int DW = IN_WIDTH + a2c_pkg::R_FRAC;
   localparam int PW = a2c_pkg::QUEUE_PTR_W;
   localparam int OW = ANGLE_FRAC_BITS + 3;
   localparam int OTD = ((ANGLE_FRAC_BITS + 3 + 7) / 8) * 8;

   logic                           req_acc, rsp_acc;
   logic [PW:0]                    occ_ff, occ_in;

   logic signed [IN_WIDTH-1:0]     y_in, x_in;

   logic                           fr_valid;
   logic [DW-1:0]                  fr_dividend;
   logic [IN_WIDTH:0]              fr_divisor;
   a2c_pkg::flags_type             fr_flags;

   logic                           dv_valid;
   logic [a2c_pkg::Q_WIDTH-1:0]    dv_quot;
   a2c_pkg::flags_type             dv_flags;

   logic                           pl_valid;
   logic [OW-1:0]                  pl_angle;
   logic [OW-1:0]                  angle_out;

   assign y_in = req_tdata[IN_WIDTH-1:0];
   assign x_in = req_tdata[2*IN_WIDTH-1:IN_WIDTH];

   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_tvalid & rsp_tready;
   assign req_tready = occ_ff < (PW+1)'(a2c_pkg::QUEUE_DEPTH);
   assign occ_in     = occ_ff + (PW+1)'(req_acc) - (PW+1)'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a2c_front #(
      .IN_WIDTH(IN_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_acc),
      .in_y        (y_in),
      .in_x        (x_in),
      .out_valid   (fr_valid),
      .out_dividend(fr_dividend),
      .out_divisor (fr_divisor),
      .out_flags   (fr_flags)
   );

   a2c_div #(
      .IN_WIDTH(IN_WIDTH)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fr_valid),
      .in_dividend(fr_dividend),
      .in_divisor (fr_divisor),
      .in_flags   (fr_flags),
      .out_valid  (dv_valid),
      .out_quot   (dv_quot),
      .out_flags  (dv_flags)
   );

   a2c_poly #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_poly (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dv_valid),
      .in_quot  (dv_quot),
      .in_flags (dv_flags),
      .out_valid(pl_valid),
      .out_angle(pl_angle)
   );

   a2c_fifo #(
      .DATA_WIDTH(OW)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(pl_valid),
      .wr_data (pl_angle),
      .rd_valid(rsp_tvalid),
      .rd_ready(rsp_tready),
      .rd_data (angle_out)
   );

   assign rsp_tdata = OTD'(angle_out);

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for atan2_cubic_approx, one angle checked per (y, x) request
// depends on a2c_pkg and atan2_cubic_approx; directed table first, then random pairs
// under several sender idle and receiver stall mixes, compared with an in-bench fixed-point model
`default_nettype none

module testbench;

   localparam int IN_W = 16;
   localparam int FRAC = 13;
   localparam int RANDOM_PER_PHASE = 300;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   // pi times mult over 2^shift, rounded, at FRAC fractional bits
   function automatic longint pi_scaled(input int mult, input int shift);
      logic [67:0] prod;
      int s;
      prod = 68'(a2c_pkg::PI_Q60) * 68'(mult);
      s = 60 + shift - FRAC;
      return longint'((prod + (68'd1 << (s - 1))) >> s);
   endfunction

   localparam longint QUARTER_PI = pi_scaled(1, 2);
   localparam longint THREE_QUARTER_PI = pi_scaled(3, 2);
   localparam longint FULL_PI = pi_scaled(1, 0);

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic               fixed;
      logic [15:0]        angle;
   } pair_row_type;

   localparam int NUM_ROWS = 22;
   localparam pair_row_type DIRECTED [NUM_ROWS] = '{
      '{16'sd0, 16'sd0, 1'b1, 16'd12868},
      '{16'sd0, 16'sh7fff, 1'b0, 16'd0},
      '{16'sd0, 16'sh8000, 1'b0, 16'd0},
      '{16'sd0, -16'sd1, 1'b0, 16'd0},
      '{16'sd0, 16'sd1, 1'b0, 16'd0},
      '{-16'sd1, 16'sd0, 1'b0, 16'd0},
      '{-16'sd1, 16'sh8000, 1'b0, 16'd0},
      '{16'sh7fff, 16'sd0, 1'b0, 16'd0},
      '{16'sh8000, 16'sd0, 1'b0, 16'd0},
      '{16'sh8000, 16'sh8000, 1'b0, 16'd0},
      '{16'sh7fff, 16'sh7fff, 1'b0, 16'd0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'd0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'd0},
      '{16'sh8000, -16'sd1, 1'b0, 16'd0},
      '{16'sd1, 16'sd1, 1'b0, 16'd0},
      '{-16'sd1, -16'sd1, 1'b0, 16'd0},
      '{16'sd1, -16'sd1, 1'b0, 16'd0},
      '{-16'sd1, 16'sd1, 1'b0, 16'd0},
      '{16'sd100, -16'sd100, 1'b0, 16'd0},
      '{-16'sd100, -16'sd100, 1'b0, 16'd0},
      '{16'sh5555, 16'shaaaa, 1'b0, 16'd0},
      '{16'shaaaa, 16'sh5555, 1'b0, 16'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // y_in, x_in
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // angle_out
   logic [15:0] rsp_tdata;

   logic [15:0] angle_queue [$];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          error_count = 0;
   int          request_count = 0;
   int          response_count = 0;
   int          quiet_cycles = 0;
   int          hold_count = 0;
   bit          want_hold = 1'b0;
   bit          hold_done = 1'b0;

   atan2_cubic_approx #(
      .IN_WIDTH(IN_W),
      .ANGLE_FRAC_BITS(FRAC)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // v / 2^s, half away from zero
   function automatic longint round_shift(input longint v, input int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 <<< (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic logic [15:0] predict_angle(input logic signed [15:0] y,
                                                 input logic signed [15:0] x);
      longint yv, xv, ay, num, den, base, mag, r, r2, t, angle;
      yv = y;
      xv = x;
      ay = ((yv < 0) ? -yv : yv) + 1;
      if (xv < 0) begin
         num = xv + ay;
         den = ay - xv;
         base = THREE_QUARTER_PI;
      end else begin
         num = xv - ay;
         den = xv + ay;
         base = QUARTER_PI;
      end
      mag = (num < 0) ? -num : num;
      r = ((mag <<< a2c_pkg::R_FRAC) + (den >>> 1)) / den;
      if (num < 0)
         r = -r;
      r2 = round_shift(r * r, a2c_pkg::R_FRAC);
      t = round_shift(longint'(a2c_pkg::COEF_C3) * r2, a2c_pkg::R_FRAC)
          - longint'(a2c_pkg::COEF_C1);
      angle = base + round_shift(t * r, 2 * a2c_pkg::R_FRAC - FRAC);
      if (yv < 0)
         angle = -angle;
      if (angle > FULL_PI)
         angle = FULL_PI;
      if (angle < -FULL_PI)
         angle = -FULL_PI;
      return angle[15:0];
   endfunction

   // called at a rising edge, returns at the edge where the request is taken
   task automatic send_pair(input logic signed [15:0] y, input logic signed [15:0] x,
                            input logic fixed, input logic [15:0] fixed_angle);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {x, y};
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
      angle_queue.push_back(fixed ? fixed_angle : predict_angle(y, x));
      request_count++;
   endtask

   task automatic pick_pair(output logic signed [15:0] y, output logic signed [15:0] x);
      logic signed [15:0] edges [6];
      logic signed [15:0] v;
      edges = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
      case ($urandom_range(5))
         0, 1: begin
            y = 16'($urandom);
            x = 16'($urandom);
         end
         2: begin
            y = 16'($urandom_range(16)) - 16'sd8;
            x = 16'($urandom_range(16)) - 16'sd8;
         end
         3: begin
            y = edges[$urandom_range(5)];
            x = edges[$urandom_range(5)];
         end
         4: begin
            v = 16'($urandom_range(32767));
            y = $urandom_range(1) ? -v : v;
            x = $urandom_range(1) ? -v : v;
         end
         default: begin
            y = 16'($urandom);
            x = 16'($urandom);
            if ($urandom_range(1))
               y = '0;
            else
               x = '0;
         end
      endcase
   endtask

   task automatic send_random(input int count);
      logic signed [15:0] y, x;
      for (int i = 0; i < count; i++) begin
         pick_pair(y, x);
         send_pair(y, x, 1'b0, 16'd0);
      end
   endtask

   always @(posedge clock) begin
      if (want_hold && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES)
            hold_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // values are stable at the falling edge and are what the next rising edge takes
   always @(negedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (angle_queue.size() == 0) begin
               $display("%0t unexpected response: expected none, got angle %0d",
                        $time, $signed(rsp_tdata));
               error_count++;
            end else begin
               if (rsp_tdata !== angle_queue[0]) begin
                  $display("%0t angle mismatch: expected %0d, got %0d",
                           $time, $signed(angle_queue[0]), $signed(rsp_tdata));
                  error_count++;
               end
               void'(angle_queue.pop_front());
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d angles outstanding",
                     $time, quiet_cycles, angle_queue.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++)
         send_pair(DIRECTED[i].y, DIRECTED[i].x, DIRECTED[i].fixed, DIRECTED[i].angle);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         if (phase == 0) begin
            send_random(100);
            want_hold = 1'b1;
            send_random(80);
            if (!hold_done) begin
               req_tvalid <= 1'b0;
               while (!hold_done)
                  @(posedge clock);
            end
            send_random(RANDOM_PER_PHASE - 180);
         end else begin
            send_random(RANDOM_PER_PHASE);
         end
         if (phase == 1) begin
            req_tvalid <= 1'b0;
            while (angle_queue.size() != 0)
               @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      while (angle_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests and %0d responses: directed edge pairs, then random",
               request_count, response_count);
      $display("pairs with no idling, sender idling, receiver stalling, both, and a %0d-cycle hold",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
src/a2c_pkg.sv
src/a2c_front.sv
src/a2c_div.sv
src/a2c_poly.sv
src/a2c_fifo.sv
src/atan2_cubic_approx.sv
tb/sv/testbench.sv
